/* hw/rtl/itoar_pkg.sv */
// Shared types, constants, microprogram and helpers of the integer to ASCII converter.
`default_nettype none
package itoar_pkg;

  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned NARROW_W  = 32;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned NIB_W     = 4;
  localparam int unsigned DIGITS    = 20;
  localparam int unsigned BCD_W     = DIGITS * NIB_W;
  localparam int unsigned DIG_IDX_W = $clog2(DIGITS);
  localparam int unsigned DD_BITS   = 4;
  localparam int unsigned STEPS_WIDE   = VALUE_W / DD_BITS;
  localparam int unsigned STEPS_NARROW = NARROW_W / DD_BITS;
  localparam int unsigned CNT_W     = $clog2(STEPS_WIDE + 1);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [NIB_W-1:0]  DEC_RADIX  = 4'd10;

  localparam int unsigned PC_W        = 4;
  localparam int unsigned UCODE_DEPTH = 1 << PC_W;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DABBLE,
    OP_FIND,
    OP_EMIT_SIGN,
    OP_EMIT_X0,
    OP_EMIT_X1,
    OP_EMIT_DIGIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_IN_HEX,
    COND_MORE_BITS,
    COND_NOT_NEG,
    COND_NO_PFX,
    COND_MORE_DIGITS
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_e  op;
    logic fire;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic in_hex;
    logic more_bits;
    logic neg;
    logic no_pfx;
    logic more_digits;
  } status_t;

  localparam logic [PC_W-1:0] STEP_LOAD   = 4'd0;
  localparam logic [PC_W-1:0] STEP_DABBLE = 4'd1;
  localparam logic [PC_W-1:0] STEP_FIND   = 4'd2;
  localparam logic [PC_W-1:0] STEP_PFX    = 4'd4;
  localparam logic [PC_W-1:0] STEP_DIGIT  = 4'd7;

  localparam uword_t UCODE [UCODE_DEPTH] = '{
    '{OP_LOAD,       COND_IN_HEX,      STEP_FIND},
    '{OP_DABBLE,     COND_MORE_BITS,   STEP_DABBLE},
    '{OP_FIND,       COND_NOT_NEG,     STEP_PFX},
    '{OP_EMIT_SIGN,  COND_NEXT,        STEP_LOAD},
    '{OP_NONE,       COND_NO_PFX,      STEP_DIGIT},
    '{OP_EMIT_X0,    COND_NEXT,        STEP_LOAD},
    '{OP_EMIT_X1,    COND_NEXT,        STEP_LOAD},
    '{OP_EMIT_DIGIT, COND_MORE_DIGITS, STEP_DIGIT},
    '{OP_NONE,       COND_ALWAYS,      STEP_LOAD},
    '{OP_NONE,       COND_ALWAYS,      STEP_LOAD},
    '{OP_NONE,       COND_ALWAYS,      STEP_LOAD},
    '{OP_NONE,       COND_ALWAYS,      STEP_LOAD},
    '{OP_NONE,       COND_ALWAYS,      STEP_LOAD},
    '{OP_NONE,       COND_ALWAYS,      STEP_LOAD},
    '{OP_NONE,       COND_ALWAYS,      STEP_LOAD},
    '{OP_NONE,       COND_ALWAYS,      STEP_LOAD}
  };

  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                              input logic [DD_BITS-1:0] bits);
    logic [BCD_W-1:0] b;
    b = bcd;
    for (int s = 0; s < DD_BITS; s++) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (b[d*NIB_W +: NIB_W] >= 4'd5) begin
          b[d*NIB_W +: NIB_W] = b[d*NIB_W +: NIB_W] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], bits[DD_BITS-1-s]};
    end
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] c;
    if (d < DEC_RADIX) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = (upper ? CHAR_UP_A : CHAR_LOW_A) + {4'd0, d - DEC_RADIX};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/itoar_seq.sv */
// Microcode sequencer: step counter, control ROM and conditional jumps.
`default_nettype none
module itoar_seq (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire itoar_pkg::status_t status_i,
  output itoar_pkg::ctl_t       ctl_o
);

  logic [itoar_pkg::PC_W-1:0] pc_q, pc_d;
  itoar_pkg::uword_t          uw;
  logic                       ready;
  logic                       take;

  assign uw = itoar_pkg::UCODE[pc_q];

  always_comb begin
    unique case (uw.op) inside
      itoar_pkg::OP_LOAD:       ready = status_i.in_valid;
      itoar_pkg::OP_EMIT_SIGN,
      itoar_pkg::OP_EMIT_X0,
      itoar_pkg::OP_EMIT_X1,
      itoar_pkg::OP_EMIT_DIGIT: ready = status_i.out_free;
      default:                  ready = 1'b1;
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      itoar_pkg::COND_ALWAYS:      take = 1'b1;
      itoar_pkg::COND_IN_HEX:      take = status_i.in_hex;
      itoar_pkg::COND_MORE_BITS:   take = status_i.more_bits;
      itoar_pkg::COND_NOT_NEG:     take = !status_i.neg;
      itoar_pkg::COND_NO_PFX:      take = status_i.no_pfx;
      itoar_pkg::COND_MORE_DIGITS: take = status_i.more_digits;
      default:                     take = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (ready) begin
      pc_d = take ? uw.target : pc_q + 1'b1;
    end
  end

  assign ctl_o.op   = uw.op;
  assign ctl_o.fire = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= itoar_pkg::STEP_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/itoar_dp.sv */
// Datapath: magnitude, double-dabble digit register, digit pointer and output register.
`default_nettype none
module itoar_dp (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire itoar_pkg::ctl_t               ctl_i,
  output itoar_pkg::status_t                 status_o,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  [itoar_pkg::VALUE_W-1:0]      value_i,
  input  wire                                is_signed_i,
  input  wire                                wide_i,
  input  wire                                base_hex_i,
  input  wire                                upper_case_i,
  input  wire                                hex_prefix_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [itoar_pkg::CHAR_W-1:0]       character_o,
  output logic                               last_o
);

  logic [itoar_pkg::VALUE_W-1:0]   sh_q, sh_d;
  logic [itoar_pkg::BCD_W-1:0]     bcd_q, bcd_d;
  logic [itoar_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [itoar_pkg::DIG_IDX_W-1:0] idx_q, idx_d;
  logic                            neg_q, neg_d;
  logic                            hex_q, hex_d;
  logic                            upper_q, upper_d;
  logic                            pfx_q, pfx_d;
  logic                            out_valid_q, out_valid_d;
  logic [itoar_pkg::CHAR_W-1:0]    char_q, char_d;
  logic                            last_q, last_d;

  logic [itoar_pkg::VALUE_W-1:0]   mag;
  logic [itoar_pkg::NARROW_W-1:0]  low;
  logic                            in_neg;
  logic [itoar_pkg::DIG_IDX_W-1:0] msd;
  logic [itoar_pkg::NIB_W-1:0]     cur_digit;
  logic                            out_free;

  assign low = value_i[itoar_pkg::NARROW_W-1:0];

  always_comb begin
    if (wide_i) begin
      in_neg = is_signed_i && value_i[itoar_pkg::VALUE_W-1];
      mag    = in_neg ? (~value_i + 1'b1) : value_i;
    end else begin
      in_neg = is_signed_i && low[itoar_pkg::NARROW_W-1];
      mag    = {{(itoar_pkg::VALUE_W-itoar_pkg::NARROW_W){1'b0}},
                in_neg ? (~low + 1'b1) : low};
    end
  end

  always_comb begin
    msd = '0;
    for (int i = 0; i < itoar_pkg::DIGITS; i++) begin
      if (bcd_q[i*itoar_pkg::NIB_W +: itoar_pkg::NIB_W] != '0) begin
        msd = itoar_pkg::DIG_IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd_q[idx_q*itoar_pkg::NIB_W +: itoar_pkg::NIB_W];
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    sh_d        = sh_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    hex_d       = hex_q;
    upper_d     = upper_q;
    pfx_d       = pfx_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (ctl_i.fire) begin
      unique case (ctl_i.op)
        itoar_pkg::OP_LOAD: begin
          sh_d    = wide_i ? mag
                           : {mag[itoar_pkg::NARROW_W-1:0], {itoar_pkg::NARROW_W{1'b0}}};
          bcd_d   = base_hex_i ? itoar_pkg::BCD_W'(mag) : '0;
          cnt_d   = wide_i ? itoar_pkg::CNT_W'(itoar_pkg::STEPS_WIDE)
                           : itoar_pkg::CNT_W'(itoar_pkg::STEPS_NARROW);
          neg_d   = in_neg;
          hex_d   = base_hex_i;
          upper_d = upper_case_i;
          pfx_d   = hex_prefix_i;
        end
        itoar_pkg::OP_DABBLE: begin
          bcd_d = itoar_pkg::dabble(bcd_q,
                    sh_q[itoar_pkg::VALUE_W-1 -: itoar_pkg::DD_BITS]);
          sh_d  = {sh_q[itoar_pkg::VALUE_W-itoar_pkg::DD_BITS-1:0],
                   {itoar_pkg::DD_BITS{1'b0}}};
          cnt_d = cnt_q - 1'b1;
        end
        itoar_pkg::OP_FIND: begin
          idx_d = msd;
        end
        itoar_pkg::OP_EMIT_SIGN: begin
          out_valid_d = 1'b1;
          char_d      = itoar_pkg::CHAR_MINUS;
          last_d      = 1'b0;
        end
        itoar_pkg::OP_EMIT_X0: begin
          out_valid_d = 1'b1;
          char_d      = itoar_pkg::CHAR_ZERO;
          last_d      = 1'b0;
        end
        itoar_pkg::OP_EMIT_X1: begin
          out_valid_d = 1'b1;
          char_d      = itoar_pkg::CHAR_X;
          last_d      = 1'b0;
        end
        itoar_pkg::OP_EMIT_DIGIT: begin
          out_valid_d = 1'b1;
          char_d      = itoar_pkg::digit_char(cur_digit, upper_q && hex_q);
          last_d      = (idx_q == '0);
          idx_d       = idx_q - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      neg_q       <= 1'b0;
      hex_q       <= 1'b0;
      upper_q     <= 1'b0;
      pfx_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      neg_q       <= neg_d;
      hex_q       <= hex_d;
      upper_q     <= upper_d;
      pfx_q       <= pfx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign status_o.in_valid    = in_valid_i;
  assign status_o.out_free    = out_free;
  assign status_o.in_hex      = base_hex_i;
  assign status_o.more_bits   = (cnt_q > itoar_pkg::CNT_W'(1));
  assign status_o.neg         = neg_q;
  assign status_o.no_pfx      = !(hex_q && pfx_q);
  assign status_o.more_digits = (idx_q != '0);

  assign in_stall_o  = (ctl_i.op != itoar_pkg::OP_LOAD);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

/* hw/rtl/integer_to_ascii_radix.sv */
// Top level of the integer to ASCII converter: sequencer and datapath.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_stall_o   value_i, is_signed_i, wide_i, base_hex_i,
//                                               upper_case_i, hex_prefix_i
//   out      output     out_valid_o/out_stall_i character_o, last_o
//
// A number runs through D double-dabble steps (16 for 64-bit decimal, 8 for 32-bit
// decimal, 0 for hex, 4 bits each) and then emits its n characters.
// Characters leave from the output register, in the order set by the microprogram.
// Reset clears the step counter and the output valid; the block then waits for a number.
// An output stall holds the emitting step; the next number is taken only after the last
// character is in the output register.
`default_nettype none
module integer_to_ascii_radix (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  [itoar_pkg::VALUE_W-1:0]      value_i,
  input  wire                                is_signed_i,
  input  wire                                wide_i,
  input  wire                                base_hex_i,
  input  wire                                upper_case_i,
  input  wire                                hex_prefix_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [itoar_pkg::CHAR_W-1:0]       character_o,
  output logic                               last_o
);

  itoar_pkg::ctl_t    ctl;
  itoar_pkg::status_t status;

  itoar_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctl_o    (ctl)
  );

  itoar_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .status_o     (status),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .is_signed_i  (is_signed_i),
    .wide_i       (wide_i),
    .base_hex_i   (base_hex_i),
    .upper_case_i (upper_case_i),
    .hex_prefix_i (hex_prefix_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .character_o  (character_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire
